### sv/pressure_relief_valve_regulator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pressure relief valve regulator
// Shared forms for concurrent checks clocked on the rising clock edge.
// ----------------------------------------------------------------------------
`ifndef PRESSURE_RELIEF_VALVE_REGULATOR_ASSERT_SVH
`define PRESSURE_RELIEF_VALVE_REGULATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PRV_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PRV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/prv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pressure relief valve regulator package
// Widths, fixed-point constants, register indexes and divider link types.
// ----------------------------------------------------------------------------
package prv_pkg;

   localparam int UPTIME_W  = 32;
   localparam int ADC_W     = 12;
   localparam int PULSE_W   = 12;
   localparam int VALVE_W   = 14;
   localparam int CFG_W     = 8;
   localparam int CSR_IDX_W = 2;

   localparam int RAW_W   = 28;
   localparam int PRESS_W = 28;
   localparam int GRAD_W  = 32;
   localparam int COUNT_W = 16;
   localparam int LIMIT_W = 13;
   localparam int ACC_W   = 40;

   localparam int DIV_NUM_W = 38;
   localparam int DIV_DEN_W = 32;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

   localparam int PRESS_GAIN      = 24638;
   localparam int PRESS_OFFSET    = 9165477;
   localparam int PRESS_RESET     = -104857600;
   localparam int PRESS_FRAC      = 20;
   localparam int GRAD_FLOOR      = -16777;
   localparam int VALVE_FULL      = 10000;
   localparam int VALVE_FINE_FROM = 2500;
   localparam int VALVE_RESET     = 100;
   localparam int VALVE_MAX       = VALVE_FULL + 10;
   localparam int RISING_TICKS    = 100;
   localparam int SERVO_HOLD_MS   = 2000;
   localparam int PULSE_BASE      = 1040;

   localparam logic [CSR_IDX_W-1:0] CSR_PRESSURE_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HYSTERESIS     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CONTROL_ENABLE = 2'd2;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quot;
   } div_rsp_type;

endpackage

### sv/prv_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one uptime and pressure sample transaction.
// ----------------------------------------------------------------------------
interface prv_req_if;
   import prv_pkg::*;

   logic                valid;
   logic                ready;
   logic [UPTIME_W-1:0] uptime_ms;
   logic [ADC_W-1:0]    adc_sample;

   modport source (output valid, uptime_ms, adc_sample, input ready);
   modport sink (input valid, uptime_ms, adc_sample, output ready);
endinterface

### sv/prv_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one servo command transaction.
// ----------------------------------------------------------------------------
interface prv_rsp_if;
   import prv_pkg::*;

   logic               valid;
   logic               ready;
   logic [PULSE_W-1:0] servo_pulse;
   logic               servo_enable;
   logic [VALVE_W-1:0] valve_position;

   modport source (output valid, servo_pulse, servo_enable, valve_position, input ready);
   modport sink (input valid, servo_pulse, servo_enable, valve_position, output ready);
endinterface

### sv/prv_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module prv_div (
   input  logic                 clock,
   input  logic                 reset,
   input  prv_pkg::div_req_type div_req,
   output prv_pkg::div_rsp_type div_rsp
);
   import prv_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W:0]   trial;
   logic                 fits;

   always_comb begin
      trial   = {rem_ff, num_ff[DIV_NUM_W-1]};
      fits    = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = div_req.num;
         rem_in  = '0;
         den_in  = div_req.den;
      end else if (busy_ff) begin
         // Shift the next numerator bit into the partial remainder.
         rem_in = fits ? DIV_DEN_W'(trial - {1'b0, den_ff}) : trial[DIV_DEN_W-1:0];
         num_in = {num_ff[DIV_NUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = num_ff;

endmodule

### sv/pressure_relief_valve_regulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pressure relief valve regulator
// Filters pressure and its gradient per uptime tick and ramps a relief valve.
// ----------------------------------------------------------------------------
// Channel  Direction  Contents
// req_ch   in         uptime_ms (32), adc_sample (12)
// rsp_ch   out        servo_pulse (12), servo_enable (1), valve_position (14)
// csr_*    in         write enable, 2-bit register index, 8-bit write data
//
// A tick whose uptime advances runs four divisions one after another on the
// shared bit-serial divider, each a setup state and then a wait state while
// the quotient bits shift out until done, after the accept and uptime check
// and around the decision, followed by delivery. A tick whose uptime does not
// advance only forms the servo pulse. Reset is synchronous. A finished
// transaction waits in the output register while the next request is taken;
// if the consumer still stalls when the next result is ready, the sequencer
// holds until the output register frees.
// ----------------------------------------------------------------------------
`include "pressure_relief_valve_regulator_assert.svh"

module pressure_relief_valve_regulator (
   input  logic                          clock,
   input  logic                          reset,
   prv_req_if.sink                       req_ch,
   prv_rsp_if.source                     rsp_ch,
   input  logic                          csr_write_enable,
   input  logic [prv_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [prv_pkg::CFG_W-1:0]     csr_write_data
);
   import prv_pkg::*;

   // Sequencer states.
   localparam logic [3:0] ST_IDLE        = 4'd0;
   localparam logic [3:0] ST_PRE         = 4'd1;
   localparam logic [3:0] ST_FP_SETUP    = 4'd2;
   localparam logic [3:0] ST_FP_DIV      = 4'd3;
   localparam logic [3:0] ST_GRAD_SETUP  = 4'd4;
   localparam logic [3:0] ST_GRAD_DIV    = 4'd5;
   localparam logic [3:0] ST_FG_SETUP    = 4'd6;
   localparam logic [3:0] ST_FG_DIV      = 4'd7;
   localparam logic [3:0] ST_DECIDE      = 4'd8;
   localparam logic [3:0] ST_PULSE_SETUP = 4'd9;
   localparam logic [3:0] ST_PULSE_DIV   = 4'd10;
   localparam logic [3:0] ST_DELIVER     = 4'd11;

   logic [3:0] state_ff, state_in;

   // Configuration registers.
   logic [CFG_W-1:0] limit_cfg_ff;
   logic [CFG_W-1:0] hyst_cfg_ff;
   logic             enable_cfg_ff;

   // Captured transaction and per-tick working values.
   logic [UPTIME_W-1:0]     now_ff;
   logic [ADC_W-1:0]        adc_ff;
   logic [UPTIME_W-1:0]     dt_ff;
   logic signed [RAW_W-1:0] raw_ff;
   logic signed [GRAD_W-1:0] grad_ff;
   logic                    neg_ff;

   // Regulator state.
   logic signed [PRESS_W-1:0] fp_ff;
   logic signed [PRESS_W-1:0] prev_fp_ff;
   logic signed [GRAD_W-1:0]  fg_ff;
   logic [COUNT_W-1:0]        count_ff;
   logic [VALVE_W-1:0]        valve_ff;
   logic signed [LIMIT_W-1:0] limit_ff;
   logic [UPTIME_W-1:0]       last_uptime_ff;
   logic [UPTIME_W-1:0]       last_move_ff;

   // Output register.
   logic               rsp_valid_ff;
   logic [PULSE_W-1:0] pulse_ff;
   logic [PULSE_W-1:0] rsp_pulse_ff;
   logic               rsp_enable_ff;
   logic [VALVE_W-1:0] rsp_valve_ff;

   div_req_type div_req;
   div_rsp_type div_rsp;

   prv_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Signed accumulator feeding the divider, selected by the setup state. The
   // divider sees the magnitude plus half the divisor, so that the quotient is
   // rounded to nearest with ties away from zero once the sign is put back.
   logic signed [ACC_W-1:0]  acc;
   logic [ACC_W-1:0]         acc_mag;
   logic [DIV_NUM_W-1:0]     half;
   logic signed [PRESS_W:0]  dp;
   logic                     div_start;
   logic signed [DIV_NUM_W:0] quot_signed;
   logic signed [RAW_W:0]    raw_full;

   always_comb begin
      dp   = (PRESS_W+1)'(fp_ff) - (PRESS_W+1)'(prev_fp_ff);
      acc  = '0;
      half = '0;
      div_req.den = '0;
      unique case (state_ff)
         ST_FP_SETUP: begin
            acc  = ACC_W'(fp_ff) * 40'sd999 + ACC_W'(raw_ff);
            half = DIV_NUM_W'(500);
            div_req.den = DIV_DEN_W'(1000);
         end
         ST_GRAD_SETUP: begin
            // Gradient in Q7.24 per millisecond is dp * 16 / dt.
            acc  = ACC_W'(dp) <<< 4;
            half = DIV_NUM_W'(dt_ff >> 1);
            div_req.den = dt_ff;
         end
         ST_FG_SETUP: begin
            acc  = ACC_W'(fg_ff) * 40'sd99 + ACC_W'(grad_ff);
            half = DIV_NUM_W'(50);
            div_req.den = DIV_DEN_W'(100);
         end
         ST_PULSE_SETUP: begin
            acc  = $signed(ACC_W'(valve_ff) * ACC_W'(95));
            half = DIV_NUM_W'(500);
            div_req.den = DIV_DEN_W'(1000);
         end
         default: begin
            acc  = '0;
         end
      endcase
      acc_mag   = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
      div_start = (state_ff == ST_FP_SETUP) || (state_ff == ST_GRAD_SETUP) ||
                  (state_ff == ST_FG_SETUP) || (state_ff == ST_PULSE_SETUP);
      div_req.start = div_start;
      div_req.num   = acc_mag[DIV_NUM_W-1:0] + half;

      quot_signed = neg_ff ? -$signed({1'b0, div_rsp.quot}) : $signed({1'b0, div_rsp.quot});

      raw_full = $signed((RAW_W+1)'(adc_ff)) * $signed((RAW_W+1)'(PRESS_GAIN))
                 - $signed((RAW_W+1)'(PRESS_OFFSET));
   end

   // Step decision: rising run count, threshold with hysteresis, valve ramp.
   logic [COUNT_W-1:0]        count_next;
   logic signed [33:0]        raw_x10;
   logic signed [33:0]        limit_scaled;
   logic                      regulate;
   logic [LIMIT_W-1:0]        limit_base;
   logic signed [GRAD_W-1:0]  grad_sat;

   always_comb begin
      if (fg_ff >= GRAD_W'(GRAD_FLOOR)) begin
         count_next = (count_ff == {COUNT_W{1'b1}}) ? count_ff : count_ff + 1'b1;
      end else begin
         count_next = '0;
      end
      raw_x10      = 34'(raw_ff) * 34'sd10;
      limit_scaled = 34'(limit_ff) <<< PRESS_FRAC;
      regulate     = (raw_x10 > limit_scaled) && enable_cfg_ff;
      limit_base   = LIMIT_W'(limit_cfg_ff) * LIMIT_W'(10);

      // The quotient is a magnitude; clamp the signed gradient to 32 bits.
      if (!neg_ff && (div_rsp.quot > DIV_NUM_W'(32'h7FFF_FFFF))) begin
         grad_sat = {1'b0, {(GRAD_W-1){1'b1}}};
      end else if (neg_ff && (div_rsp.quot > DIV_NUM_W'(33'h0_8000_0000))) begin
         grad_sat = {1'b1, {(GRAD_W-1){1'b0}}};
      end else begin
         grad_sat = quot_signed[GRAD_W-1:0];
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:        if (req_ch.valid) state_in = ST_PRE;
         ST_PRE:         state_in = (now_ff > last_uptime_ff) ? ST_FP_SETUP : ST_PULSE_SETUP;
         ST_FP_SETUP:    state_in = ST_FP_DIV;
         ST_FP_DIV:      if (div_rsp.done) state_in = ST_GRAD_SETUP;
         ST_GRAD_SETUP:  state_in = ST_GRAD_DIV;
         ST_GRAD_DIV:    if (div_rsp.done) state_in = ST_FG_SETUP;
         ST_FG_SETUP:    state_in = ST_FG_DIV;
         ST_FG_DIV:      if (div_rsp.done) state_in = ST_DECIDE;
         ST_DECIDE:      state_in = ST_PULSE_SETUP;
         ST_PULSE_SETUP: state_in = ST_PULSE_DIV;
         ST_PULSE_DIV:   if (div_rsp.done) state_in = ST_DELIVER;
         ST_DELIVER:     if (!rsp_valid_ff || rsp_ch.ready) state_in = ST_IDLE;
         default:        state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         limit_cfg_ff   <= CFG_W'(30);
         hyst_cfg_ff    <= CFG_W'(10);
         enable_cfg_ff  <= 1'b1;
         fp_ff          <= PRESS_W'(PRESS_RESET);
         prev_fp_ff     <= PRESS_W'(PRESS_RESET);
         fg_ff          <= '0;
         count_ff       <= '0;
         valve_ff       <= VALVE_W'(VALVE_RESET);
         limit_ff       <= '0;
         last_uptime_ff <= '0;
         last_move_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_PRESSURE_LIMIT: limit_cfg_ff  <= csr_write_data;
               CSR_HYSTERESIS:     hyst_cfg_ff   <= csr_write_data;
               CSR_CONTROL_ENABLE: enable_cfg_ff <= csr_write_data[0];
               default:            ;
            endcase
         end

         if ((state_ff == ST_PRE) && (now_ff > last_uptime_ff)) begin
            last_uptime_ff <= now_ff;
         end
         if ((state_ff == ST_FP_DIV) && div_rsp.done) begin
            fp_ff <= quot_signed[PRESS_W-1:0];
         end
         if ((state_ff == ST_FG_DIV) && div_rsp.done) begin
            fg_ff <= quot_signed[GRAD_W-1:0];
         end

         if (state_ff == ST_DECIDE) begin
            count_ff   <= count_next;
            prev_fp_ff <= fp_ff;
            if (regulate) begin
               limit_ff <= $signed(limit_base - LIMIT_W'(hyst_cfg_ff));
               if ((count_next > COUNT_W'(RISING_TICKS)) &&
                   (valve_ff < VALVE_W'(VALVE_FULL))) begin
                  valve_ff <= (valve_ff < VALVE_W'(VALVE_FINE_FROM)) ?
                              valve_ff + VALVE_W'(10) : valve_ff + VALVE_W'(2);
                  last_move_ff <= now_ff;
               end
            end else begin
               limit_ff <= $signed(limit_base);
               if (valve_ff != '0) begin
                  valve_ff     <= '0;
                  last_move_ff <= now_ff;
               end
            end
         end

         // Output register: load when the sequencer delivers, drop on pickup.
         if ((state_ff == ST_DELIVER) && (!rsp_valid_ff || rsp_ch.ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      // Payload registers need no reset.
      if ((state_ff == ST_IDLE) && req_ch.valid) begin
         now_ff <= req_ch.uptime_ms;
         adc_ff <= req_ch.adc_sample;
      end
      if (state_ff == ST_PRE) begin
         dt_ff  <= now_ff - last_uptime_ff;
         raw_ff <= raw_full[RAW_W-1:0];
      end
      if (div_start) begin
         neg_ff <= acc[ACC_W-1];
      end
      if ((state_ff == ST_GRAD_DIV) && div_rsp.done) begin
         grad_ff <= grad_sat;
      end
      if ((state_ff == ST_PULSE_DIV) && div_rsp.done) begin
         pulse_ff <= PULSE_W'((PULSE_W'(PULSE_BASE) + PULSE_W'(div_rsp.quot)) << 1);
      end
      if ((state_ff == ST_DELIVER) && (!rsp_valid_ff || rsp_ch.ready)) begin
         rsp_pulse_ff  <= pulse_ff;
         rsp_enable_ff <= ({1'b0, last_move_ff} + (UPTIME_W+1)'(SERVO_HOLD_MS)) >
                          {1'b0, last_uptime_ff};
         rsp_valve_ff  <= valve_ff;
      end
   end

   assign req_ch.ready          = (state_ff == ST_IDLE);
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.servo_pulse    = rsp_pulse_ff;
   assign rsp_ch.servo_enable   = rsp_enable_ff;
   assign rsp_ch.valve_position = rsp_valve_ff;

   // The divider finishes only while the sequencer waits for it.
   `PRV_ASSERT_SAME(a_div_done_wait, clock, reset, div_rsp.done,
      (state_ff == ST_FP_DIV) || (state_ff == ST_GRAD_DIV) ||
      (state_ff == ST_FG_DIV) || (state_ff == ST_PULSE_DIV),
      "divider finished outside a wait state")
   // The valve never ramps past full opening plus one coarse step.
   `PRV_ASSERT_SAME(a_valve_range, clock, reset, 1'b1,
      valve_ff <= VALVE_W'(VALVE_MAX), "valve opening out of range")
   // A decision step always leaves the previous pressure equal to the filtered one.
   `PRV_ASSERT_NEXT(a_prev_follows, clock, reset, state_ff == ST_DECIDE,
      prev_fp_ff == fp_ff, "previous pressure not updated after decision")
   // An accepted request always starts with the uptime check.
   `PRV_ASSERT_NEXT(a_accept_pre, clock, reset, req_ch.valid && req_ch.ready,
      state_ff == ST_PRE, "accepted request did not enter the uptime check")

endmodule
